@@ design/gcl_pkg.sv @@
// ----------------------------------------------------------------------------
// gcl_pkg : shared definitions for the gesture code lock
// Field widths, register indexes, reset values, event codes and the phase
// state encoding.
// ----------------------------------------------------------------------------
package gcl_pkg;

    // Field widths
    localparam int SAMPLE_W = 12;
    localparam int THR_W    = 12;
    localparam int DIGIT_W  = 2;
    localparam int COUNT_W  = 5;
    localparam int PHASE_W  = 2;
    localparam int EVENT_W  = 3;

    // Default code length (digits in the stored code)
    localparam int CODE_LENGTH_DEF = 4;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 1;
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_LOW_THR  = 1'b0,
        REG_HIGH_THR = 1'b1
    } cfg_reg_t;

    // Threshold reset values
    localparam logic [THR_W-1:0] LOW_THR_RST  = 12'd100;
    localparam logic [THR_W-1:0] HIGH_THR_RST = 12'd4000;

    // Input kinds
    localparam logic MODE_SAMPLE  = 1'b0;
    localparam logic MODE_CONFIRM = 1'b1;

    // Result event codes
    typedef enum logic [EVENT_W-1:0] {
        EV_NONE         = 3'd0,
        EV_ENROLL_DIGIT = 3'd1,
        EV_ENROLL_DONE  = 3'd2,
        EV_CONFIRMED    = 3'd3,
        EV_OPENED       = 3'd4,
        EV_LOCKED       = 3'd5,
        EV_WRONG_CODE   = 3'd6
    } event_t;

    // Gesture digits (gestures 1..4)
    localparam logic [DIGIT_W-1:0] DIG_X_LOW  = 2'd0;
    localparam logic [DIGIT_W-1:0] DIG_X_HIGH = 2'd1;
    localparam logic [DIGIT_W-1:0] DIG_Y_LOW  = 2'd2;
    localparam logic [DIGIT_W-1:0] DIG_Y_HIGH = 2'd3;

    // Lock phase state, one-hot
    typedef enum logic [3:0] {
        PH_ENROLL   = 4'b0001,
        PH_AWAIT    = 4'b0010,
        PH_TO_OPEN  = 4'b0100,
        PH_TO_CLOSE = 4'b1000
    } phase_t;

    // Reported phase codes
    localparam logic [PHASE_W-1:0] PHASE_CODE_ENROLL   = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_CODE_AWAIT    = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_CODE_TO_OPEN  = 2'd2;
    localparam logic [PHASE_W-1:0] PHASE_CODE_TO_CLOSE = 2'd3;

    // One result item
    typedef struct packed {
        event_t               ev;
        logic [DIGIT_W-1:0]   digit;
        logic [COUNT_W-1:0]   digit_count;
        logic                 is_locked;
        logic [PHASE_W-1:0]   phase;
    } result_t;

    function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
        logic [PHASE_W-1:0] code;
        begin
            case (ph)
                PH_ENROLL:   code = PHASE_CODE_ENROLL;
                PH_AWAIT:    code = PHASE_CODE_AWAIT;
                PH_TO_OPEN:  code = PHASE_CODE_TO_OPEN;
                PH_TO_CLOSE: code = PHASE_CODE_TO_CLOSE;
                default:     code = PHASE_CODE_ENROLL;
            endcase
            return code;
        end
    endfunction

endpackage

@@ design/gesture_code_lock.sv @@
// ----------------------------------------------------------------------------
// gesture_code_lock : joystick gesture combination lock
// Classifies joystick samples into gesture digits, enrols a code, then
// toggles the lock on each correct entry of that code.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_tvalid/s_tready): one transfer per joystick sample or
//   confirm press; s_tuser = mode (1 = confirm), s_tdata = {y, x}.
//   Output stream (m_tvalid/m_tready): exactly one result transfer per
//   input transfer, in order; m_tuser = event code, m_tdata carries digit,
//   digit count, lock flag and phase.
//   Config port: cfg_we/cfg_addr/cfg_wdata set the low (index 0) and high
//   (index 1) deflection thresholds; write only while the block is idle.
// Pipeline: two register stages (input register, then result register);
//   an item passes from the input register to the result register, which
//   drives m_tvalid. Throughput: one item per cycle while m_tready does not
//   hold the result register; the lock state is updated at the same edge
//   as an item moves from the input register to the result register.
// Reset: thresholds go to 100 and 4000, phase to enrol, count and flags
//   clear, re-armed; the code store holds nothing until enrolled.
// Stall: while m_tready is low the result register holds, the input
//   register takes one more item, and s_tready then drops.
// ----------------------------------------------------------------------------
module gesture_code_lock
    import gcl_pkg::*;
#(
    parameter int CODE_LENGTH = CODE_LENGTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // config write port
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [THR_W-1:0]       cfg_wdata,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [23:0]            s_tdata,   // [11:0] x_sample, [23:12] y_sample
    input  logic                   s_tuser,   // [0] mode
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [15:0]            m_tdata,   // [1:0] digit, [6:2] digit_count,
                                              // [7] is_locked, [9:8] phase, rest 0
    output logic [EVENT_W-1:0]     m_tuser    // [2:0] event_res
);

    localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
    localparam logic [COUNT_W-1:0] CODE_LEN_C = COUNT_W'(CODE_LENGTH);

    // Configuration registers
    logic [THR_W-1:0] low_thr_reg;
    logic [THR_W-1:0] high_thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_thr_reg  <= LOW_THR_RST;
            high_thr_reg <= HIGH_THR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_LOW_THR:  low_thr_reg  <= cfg_wdata;
                REG_HIGH_THR: high_thr_reg <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    // Handshake: input register feeds result register
    logic                in_valid_reg;
    logic                in_mode_reg;
    logic [SAMPLE_W-1:0] in_x_reg;
    logic [SAMPLE_W-1:0] in_y_reg;
    logic                out_valid_reg;
    result_t             out_reg;
    logic                advance;
    logic                fire;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_mode_reg <= s_tuser;
            in_x_reg    <= s_tdata[SAMPLE_W-1:0];
            in_y_reg    <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
        end
    end

    // Lock state
    logic [DIGIT_W-1:0] code_reg [CODE_LENGTH];
    logic [COUNT_W-1:0] entry_count_reg, entry_count_next;
    logic               rearmed_reg, rearmed_next;
    phase_t             phase_reg, phase_next;
    logic               mismatch_reg, mismatch_next;
    logic               locked_reg, locked_next;

    // Combinational step
    logic               x_low, x_high, y_low, y_high;
    logic               hit, centered;
    logic [DIGIT_W-1:0] gesture;
    logic [COUNT_W-1:0] pos;
    logic [COUNT_W-1:0] pos_inc;
    logic [IDX_W-1:0]   pos_idx;
    logic [DIGIT_W-1:0] code_rd;
    logic               code_we;
    logic               mism;
    result_t            res;

    assign x_low    = in_x_reg <= low_thr_reg;
    assign x_high   = in_x_reg >= high_thr_reg;
    assign y_low    = in_y_reg <= low_thr_reg;
    assign y_high   = in_y_reg >= high_thr_reg;
    assign hit      = x_low || x_high || y_low || y_high;
    assign centered = !x_low && !x_high && !y_low && !y_high;

    // priority: x low, x high, y low, y high
    always_comb
    begin
        if (x_low)
            gesture = DIG_X_LOW;
        else if (x_high)
            gesture = DIG_X_HIGH;
        else if (y_low)
            gesture = DIG_Y_LOW;
        else
            gesture = DIG_Y_HIGH;
    end

    // code position, clamped to the last entry
    assign pos     = (entry_count_reg < CODE_LEN_C) ? entry_count_reg
                                                    : CODE_LEN_C - COUNT_W'(1);
    assign pos_inc = pos + COUNT_W'(1);
    assign pos_idx = pos[IDX_W-1:0];
    assign code_rd = code_reg[pos_idx];
    assign mism    = mismatch_reg || (code_rd != gesture);

    always_comb
    begin
        entry_count_next = entry_count_reg;
        rearmed_next     = rearmed_reg;
        phase_next       = phase_reg;
        mismatch_next    = mismatch_reg;
        locked_next      = locked_reg;
        code_we          = 1'b0;
        res.ev           = EV_NONE;
        res.digit        = '0;
        res.digit_count  = entry_count_reg;

        if (in_mode_reg == MODE_CONFIRM)
        begin
            // confirm press only counts after enrolment
            if (phase_reg == PH_AWAIT)
            begin
                phase_next       = PH_TO_OPEN;
                locked_next      = 1'b1;
                entry_count_next = '0;
                mismatch_next    = 1'b0;
                rearmed_next     = 1'b1;
                res.ev           = EV_CONFIRMED;
            end
        end
        else if (phase_reg != PH_AWAIT)
        begin
            if (rearmed_reg && hit)
            begin
                res.digit        = gesture;
                res.digit_count  = pos_inc;
                rearmed_next     = 1'b0;
                entry_count_next = pos_inc;
                if (phase_reg == PH_ENROLL)
                begin
                    code_we = 1'b1;
                    res.ev  = EV_ENROLL_DIGIT;
                    if (pos_inc >= CODE_LEN_C)
                    begin
                        res.ev           = EV_ENROLL_DONE;
                        entry_count_next = '0;
                        phase_next       = PH_AWAIT;
                    end
                end
                else if (pos_inc >= CODE_LEN_C)
                begin
                    // entry complete: check, and toggle on a correct code
                    if (mism)
                    begin
                        res.ev = EV_WRONG_CODE;
                    end
                    else if (phase_reg == PH_TO_OPEN)
                    begin
                        res.ev       = EV_OPENED;
                        locked_next  = 1'b0;
                        phase_next   = PH_TO_CLOSE;
                        rearmed_next = 1'b1;
                    end
                    else
                    begin
                        res.ev       = EV_LOCKED;
                        locked_next  = 1'b1;
                        phase_next   = PH_TO_OPEN;
                        rearmed_next = 1'b1;
                    end
                    entry_count_next = '0;
                    mismatch_next    = 1'b0;
                end
                else
                begin
                    mismatch_next = mism;
                end
            end
            if (centered)
                rearmed_next = 1'b1;
        end

        res.is_locked = locked_next;
        res.phase     = phase_code(phase_next);
    end

    // State update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            rearmed_reg     <= 1'b1;
            phase_reg       <= PH_ENROLL;
            mismatch_reg    <= 1'b0;
            locked_reg      <= 1'b0;
        end
        else if (fire)
        begin
            entry_count_reg <= entry_count_next;
            rearmed_reg     <= rearmed_next;
            phase_reg       <= phase_next;
            mismatch_reg    <= mismatch_next;
            locked_reg      <= locked_next;
        end
    end

    // Code store, no reset: every entry is enrolled before it is read
    always_ff @(posedge clk)
    begin
        if (fire && code_we)
            code_reg[pos_idx] <= gesture;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.ev;
    assign m_tdata  = {6'd0, out_reg.phase, out_reg.is_locked,
                       out_reg.digit_count, out_reg.digit};

    // Assertions
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg < CODE_LEN_C)
        else $error("entry count reached code length");

    a_lock_vs_phase: assert property (@(posedge clk) disable iff (!rst_n)
        locked_reg == (phase_reg == PH_TO_OPEN))
        else $error("lock flag disagrees with phase");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_x_reg)
                                     && $stable(in_y_reg) && $stable(in_mode_reg))
        else $error("input register lost an item during stall");

    a_opened_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.ev == EV_OPENED |=> !out_reg.is_locked
                                        && out_reg.phase == PHASE_CODE_TO_CLOSE)
        else $error("opened result with wrong lock state");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb : self-checking bench for the gesture code lock
// Sends joystick samples and confirm presses through the input stream and
// checks every result transfer against a cycle-free model of the lock held
// here. A short directed table walks enrolment, confirm, opening and a wrong
// code; random gesture sequences then follow under several threshold
// settings, with idle and stall patterns on both streams.
// ----------------------------------------------------------------------------
module tb;
    import gcl_pkg::*;

    localparam int CODE_LEN   = CODE_LENGTH_DEF;
    localparam int N_DIR      = 27;
    localparam int N_SETTINGS = 9;
    localparam int MAX_SHOWN  = 10;

    // one input transfer
    typedef struct packed {
        logic                mode;
        logic [SAMPLE_W-1:0] x;
        logic [SAMPLE_W-1:0] y;
    } lock_in_t;

    // directed stimulus row; res only used where typed is set
    typedef struct packed {
        lock_in_t item;
        logic     typed;
        result_t  res;
    } dir_row_t;

    localparam result_t NO_RES = '{EV_NONE, 2'd0, 5'd0, 1'b0, 2'd0};

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = REG_LOW_THR;
    logic [THR_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata   = '0;   // [11:0] x_sample, [23:12] y_sample
    logic                  s_tuser   = 1'b0; // [0] mode
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [15:0]           m_tdata;          // [1:0] digit, [6:2] digit_count,
                                             // [7] is_locked, [9:8] phase
    logic [EVENT_W-1:0]    m_tuser;          // [2:0] event_res

    // model of the lock: thresholds and state
    logic [THR_W-1:0]   thr_low;
    logic [THR_W-1:0]   thr_high;
    logic [DIGIT_W-1:0] lk_code [CODE_LEN];
    logic [COUNT_W-1:0] lk_count;
    logic               lk_rearmed;
    logic               lk_bad;
    logic               lk_locked;
    logic [PHASE_W-1:0] lk_phase;

    result_t  pending_res [$];
    lock_in_t gesture_plan [$];
    dir_row_t dir_rows [N_DIR];

    int set_low  [N_SETTINGS] = '{100, 0, 2000, 4095, 1, 1234, 0, 3000, 100};
    int set_high [N_SETTINGS] = '{4000, 4095, 2100, 0, 4094, 2900, 4095, 3002, 4000};
    int set_items[N_SETTINGS] = '{160, 160, 160, 40, 160, 160, 160, 160, 160};

    int send_idle_pct  = 10;
    int recv_stall_pct = 74;
    int n_items   = 0;
    int n_live    = 0;
    int n_results = 0;
    int n_err     = 0;
    int ev_seen [8];

    result_t want;

    gesture_code_lock i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #2 clk = ~clk;

    // next state and result of the lock for one accepted item
    function automatic result_t lock_step(input lock_in_t it, output bit ignored);
        result_t            r;
        logic               centred;
        logic               hit;
        logic [DIGIT_W-1:0] g;
        int                 pos;
        r       = NO_RES;
        ignored = 1'b0;
        if (it.mode == MODE_CONFIRM)
        begin
            if (lk_phase == PHASE_CODE_AWAIT)
            begin
                lk_phase   = PHASE_CODE_TO_OPEN;
                lk_locked  = 1'b1;
                lk_count   = '0;
                lk_bad     = 1'b0;
                lk_rearmed = 1'b1;
                r.ev       = EV_CONFIRMED;
            end
            else
            begin
                ignored = 1'b1;
            end
            r.digit_count = lk_count;
        end
        else if (lk_phase == PHASE_CODE_AWAIT)
        begin
            // samples while awaiting confirm leave everything alone
            ignored       = 1'b1;
            r.digit_count = lk_count;
        end
        else
        begin
            centred = it.x > thr_low && it.x < thr_high &&
                      it.y > thr_low && it.y < thr_high;
            hit = 1'b1;
            g   = DIG_X_LOW;
            if (it.x <= thr_low)       g = DIG_X_LOW;
            else if (it.x >= thr_high) g = DIG_X_HIGH;
            else if (it.y <= thr_low)  g = DIG_Y_LOW;
            else if (it.y >= thr_high) g = DIG_Y_HIGH;
            else                       hit = 1'b0;
            r.digit_count = lk_count;
            if (lk_rearmed && hit)
            begin
                pos        = (lk_count < CODE_LEN) ? int'(lk_count) : CODE_LEN - 1;
                r.digit    = g;
                lk_rearmed = 1'b0;
                if (lk_phase == PHASE_CODE_ENROLL)
                begin
                    lk_code[pos]  = g;
                    lk_count      = COUNT_W'(pos + 1);
                    r.digit_count = lk_count;
                    r.ev          = EV_ENROLL_DIGIT;
                    if (lk_count >= CODE_LEN)
                    begin
                        r.ev     = EV_ENROLL_DONE;
                        lk_count = '0;
                        lk_phase = PHASE_CODE_AWAIT;
                    end
                end
                else
                begin
                    if (lk_code[pos] != g) lk_bad = 1'b1;
                    lk_count      = COUNT_W'(pos + 1);
                    r.digit_count = lk_count;
                    // entry complete: toggle on a good code, restart on a bad one
                    if (lk_count >= CODE_LEN)
                    begin
                        if (lk_bad)
                        begin
                            r.ev = EV_WRONG_CODE;
                        end
                        else if (lk_phase == PHASE_CODE_TO_OPEN)
                        begin
                            r.ev       = EV_OPENED;
                            lk_locked  = 1'b0;
                            lk_phase   = PHASE_CODE_TO_CLOSE;
                            lk_rearmed = 1'b1;
                        end
                        else
                        begin
                            r.ev       = EV_LOCKED;
                            lk_locked  = 1'b1;
                            lk_phase   = PHASE_CODE_TO_OPEN;
                            lk_rearmed = 1'b1;
                        end
                        lk_count = '0;
                        lk_bad   = 1'b0;
                    end
                end
            end
            if (centred) lk_rearmed = 1'b1;
        end
        r.is_locked = lk_locked;
        r.phase     = lk_phase;
        return r;
    endfunction

    // random value in [lo, hi], leaning on the ends
    function automatic logic [SAMPLE_W-1:0] pick(input int lo, input int hi);
        int r;
        r = $urandom_range(99);
        if (r < 15) return SAMPLE_W'(lo);
        if (r < 30) return SAMPLE_W'(hi);
        return SAMPLE_W'($urandom_range(hi, lo));
    endfunction

    function automatic lock_in_t centre_item();
        lock_in_t it;
        it.mode = MODE_SAMPLE;
        it.x    = pick(int'(thr_low) + 1, int'(thr_high) - 1);
        it.y    = pick(int'(thr_low) + 1, int'(thr_high) - 1);
        return it;
    endfunction

    function automatic lock_in_t gesture_item(input logic [DIGIT_W-1:0] d);
        lock_in_t it;
        it.mode = MODE_SAMPLE;
        it.x    = SAMPLE_W'($urandom);
        it.y    = SAMPLE_W'($urandom);
        case (d)
            DIG_X_LOW:  it.x = pick(0, int'(thr_low));
            DIG_X_HIGH: it.x = pick(int'(thr_high), 4095);
            DIG_Y_LOW:
            begin
                it.x = pick(int'(thr_low) + 1, int'(thr_high) - 1);
                it.y = pick(0, int'(thr_low));
            end
            default:
            begin
                it.x = pick(int'(thr_low) + 1, int'(thr_high) - 1);
                it.y = pick(int'(thr_high), 4095);
            end
        endcase
        return it;
    endfunction

    // queue up the next stretch of stimulus from the current lock state
    task automatic plan_more();
        lock_in_t           it;
        logic [DIGIT_W-1:0] d;
        int                 wrong_at;
        bit                 sane;
        sane = int'(thr_low) + 2 <= int'(thr_high);
        if (!sane || $urandom_range(99) < 12)
        begin
            // noise: anything the fields allow
            repeat ($urandom_range(3, 1))
            begin
                it.mode = 1'($urandom_range(1, 0));
                it.x    = SAMPLE_W'($urandom);
                it.y    = SAMPLE_W'($urandom);
                gesture_plan.push_back(it);
            end
        end
        else if (lk_phase == PHASE_CODE_AWAIT)
        begin
            it = centre_item();
            if ($urandom_range(99) < 85) it.mode = MODE_CONFIRM;
            gesture_plan.push_back(it);
        end
        else
        begin
            // a whole code entry, gesture then centre for each digit, at times with a confirm press between
            if (!lk_rearmed) gesture_plan.push_back(centre_item());
            wrong_at = ($urandom_range(99) < 25) ? $urandom_range(CODE_LEN - 1, 0) : -1;
            for (int k = 0; k < CODE_LEN; k++)
            begin
                if (lk_phase == PHASE_CODE_ENROLL)
                    d = DIGIT_W'($urandom_range(3, 0));
                else
                    d = DIGIT_W'(lk_code[k] + ((k == wrong_at) ? $urandom_range(3, 1) : 0));
                gesture_plan.push_back(gesture_item(d));
                if ($urandom_range(99) < 5)
                begin
                    it      = centre_item();
                    it.mode = MODE_CONFIRM;
                    gesture_plan.push_back(it);
                end
                gesture_plan.push_back(centre_item());
            end
        end
    endtask

    // present one item, wait for the transfer, record what must come back
    task automatic send_item(input lock_in_t it, input bit typed, input result_t typed_res);
        result_t pred;
        bit      ign;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.mode;
        s_tdata  <= {it.y, it.x};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pred = lock_step(it, ign);
        pending_res.push_back(typed ? typed_res : pred);
        n_items++;
        if (!ign) n_live++;
    endtask

    task automatic wait_idle(input int tail);
        while (pending_res.size() != 0) @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    task automatic write_thresholds(input int lo, input int hi);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_LOW_THR;
        cfg_wdata <= THR_W'(lo);
        thr_low    = THR_W'(lo);
        @(posedge clk);
        cfg_addr  <= REG_HIGH_THR;
        cfg_wdata <= THR_W'(hi);
        thr_high   = THR_W'(hi);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            n_results++;
            if (pending_res.size() == 0)
            begin
                n_err++;
                if (n_err <= MAX_SHOWN)
                    $display("%0t: result with nothing outstanding: ev=%0d data=%h",
                             $realtime, m_tuser, m_tdata);
            end
            else
            begin
                want = pending_res.pop_front();
                ev_seen[int'(want.ev)]++;
                if (m_tuser !== want.ev || m_tdata[1:0] !== want.digit ||
                    m_tdata[6:2] !== want.digit_count || m_tdata[7] !== want.is_locked ||
                    m_tdata[9:8] !== want.phase)
                begin
                    n_err++;
                    if (n_err <= MAX_SHOWN)
                        $display({"%0t: result %0d mismatch: expected ev=%0d dig=%0d cnt=%0d ",
                                  "lk=%0d ph=%0d, got ev=%0d dig=%0d cnt=%0d lk=%0d ph=%0d"},
                                 $realtime, n_results, want.ev, want.digit,
                                 want.digit_count, want.is_locked, want.phase, m_tuser,
                                 m_tdata[1:0], m_tdata[6:2], m_tdata[7], m_tdata[9:8]);
                end
            end
        end
    end

    // stimulus
    initial
    begin
        int base;
        int tries;
        thr_low    = LOW_THR_RST;
        thr_high   = HIGH_THR_RST;
        lk_count   = '0;
        lk_rearmed = 1'b1;
        lk_bad     = 1'b0;
        lk_locked  = 1'b0;
        lk_phase   = PHASE_CODE_ENROLL;
        foreach (lk_code[k]) lk_code[k] = '0;
        foreach (ev_seen[k]) ev_seen[k] = 0;

        // enrol 0,1,2,3; confirm; open; then a wrong code while closing
        dir_rows = '{
            '{'{MODE_CONFIRM, 0, 0}, 1'b1,
              '{EV_NONE, 2'd0, 5'd0, 1'b0, PHASE_CODE_ENROLL}},
            '{'{MODE_SAMPLE, 0, 2048}, 1'b1,
              '{EV_ENROLL_DIGIT, DIG_X_LOW, 5'd1, 1'b0, PHASE_CODE_ENROLL}},
            '{'{MODE_SAMPLE, 4095, 4095}, 1'b0, NO_RES},   // not re-armed
            '{'{MODE_SAMPLE, 101, 3999}, 1'b0, NO_RES},    // just inside
            '{'{MODE_SAMPLE, 4095, 0}, 1'b1,
              '{EV_ENROLL_DIGIT, DIG_X_HIGH, 5'd2, 1'b0, PHASE_CODE_ENROLL}},
            '{'{MODE_SAMPLE, 2048, 2048}, 1'b0, NO_RES},
            '{'{MODE_SAMPLE, 2048, 100}, 1'b0, NO_RES},    // y on low threshold
            '{'{MODE_SAMPLE, 100, 4000}, 1'b0, NO_RES},    // on both, not centred
            '{'{MODE_SAMPLE, 3999, 101}, 1'b0, NO_RES},
            '{'{MODE_SAMPLE, 2048, 4000}, 1'b1,
              '{EV_ENROLL_DONE, DIG_Y_HIGH, 5'd4, 1'b0, PHASE_CODE_AWAIT}},
            '{'{MODE_SAMPLE, 0, 0}, 1'b0, NO_RES},         // ignored while awaiting
            '{'{MODE_CONFIRM, 4095, 4095}, 1'b1,
              '{EV_CONFIRMED, 2'd0, 5'd0, 1'b1, PHASE_CODE_TO_OPEN}},
            '{'{MODE_SAMPLE, 0, 4095}, 1'b0, NO_RES},
            '{'{MODE_SAMPLE, 2048, 2048}, 1'b0, NO_RES},
            '{'{MODE_SAMPLE, 4000, 2048}, 1'b0, NO_RES},
            '{'{MODE_SAMPLE, 1000, 1000}, 1'b0, NO_RES},
            '{'{MODE_SAMPLE, 2048, 0}, 1'b0, NO_RES},
            '{'{MODE_SAMPLE, 2048, 2048}, 1'b0, NO_RES},
            '{'{MODE_SAMPLE, 2048, 4095}, 1'b1,
              '{EV_OPENED, DIG_Y_HIGH, 5'd4, 1'b0, PHASE_CODE_TO_CLOSE}},
            '{'{MODE_CONFIRM, 0, 0}, 1'b1,
              '{EV_NONE, 2'd0, 5'd0, 1'b0, PHASE_CODE_TO_CLOSE}},
            '{'{MODE_SAMPLE, 0, 2048}, 1'b0, NO_RES},
            '{'{MODE_SAMPLE, 2048, 2048}, 1'b0, NO_RES},
            '{'{MODE_SAMPLE, 4095, 2048}, 1'b0, NO_RES},
            '{'{MODE_SAMPLE, 2048, 2048}, 1'b0, NO_RES},
            '{'{MODE_SAMPLE, 2048, 0}, 1'b0, NO_RES},
            '{'{MODE_SAMPLE, 2048, 2048}, 1'b0, NO_RES},
            '{'{MODE_SAMPLE, 0, 2048}, 1'b1,
              '{EV_WRONG_CODE, DIG_X_LOW, 5'd4, 1'b0, PHASE_CODE_TO_CLOSE}}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (dir_rows[k])
            send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].res);

        // random phases, each writing its thresholds and setting idle and stall patterns
        for (int p = 0; p < N_SETTINGS; p++)
        begin
            s_tvalid <= 1'b0;
            wait_idle(4);
            send_idle_pct  = (p / 3 == 0) ? 10 : (p / 3 == 1) ? 74 : 0;
            recv_stall_pct = (p / 3 == 0) ? 74 : (p / 3 == 1) ? 10 : 0;
            write_thresholds(set_low[p], set_high[p]);
            base  = n_live;
            tries = 0;
            while (n_live - base < set_items[p] && tries < 4 * set_items[p])
            begin
                if (gesture_plan.size() == 0) plan_more();
                send_item(gesture_plan.pop_front(), 1'b0, NO_RES);
                tries++;
            end
            gesture_plan.delete();
        end
        s_tvalid <= 1'b0;
        wait_idle(8);

        $display("Sent %0d items (%0d acting on the lock) under %0d threshold settings.",
                 n_items, n_live, N_SETTINGS + 1);
        $display({"Checked %0d results: %0d openings, %0d lockings, ",
                  "%0d wrong codes, %0d enrolments."},
                 n_results, ev_seen[EV_OPENED], ev_seen[EV_LOCKED],
                 ev_seen[EV_WRONG_CODE], ev_seen[EV_ENROLL_DONE]);
        if (n_err == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("Timeout with %0d results outstanding", pending_res.size());
        $display("Verification failed");
        $finish;
    end

endmodule
